### hdl/scale_weight_frame_parser_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the scale weight frame parser
// Both macros expect signals named clock and reset where they are used.
// ---------------------------------------------------------------------------
`ifndef SCALE_WEIGHT_FRAME_PARSER_MACROS_SVH
`define SCALE_WEIGHT_FRAME_PARSER_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define SWFP_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define SWFP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define SWFP_ASSERT_NOW(lbl, ante, cons, msg)
`define SWFP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### hdl/swfp_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// swfp_pkg
// Types, character codes and result codes shared by the frame parser.
// ---------------------------------------------------------------------------
package swfp_pkg;

   localparam int BYTE_W   = 8;
   localparam int NUM_W    = 27;
   localparam int POS_W    = 5;
   localparam int HDR_LEN  = 7;
   localparam int TAIL_LEN = 5;

   localparam int SHORT_FRAME_LEN = 18;
   localparam int LONG_FRAME_LEN  = 21;

   // position of the line feed within a line of each accepted length
   localparam logic [POS_W-1:0] SHORT_LF_POS = POS_W'(SHORT_FRAME_LEN - 1);
   localparam logic [POS_W-1:0] LONG_LF_POS  = POS_W'(LONG_FRAME_LEN - 1);

   localparam logic [POS_W-1:0] POS_MAX        = 5'd31;
   localparam logic [POS_W-1:0] NUM_FIRST      = 5'd7;
   localparam logic [POS_W-1:0] NUM_SHORT_LAST = 5'd13;
   localparam logic [POS_W-1:0] NUM_LONG_LAST  = 5'd14;
   localparam logic [POS_W-1:0] ID_FIRST       = 5'd8;
   localparam logic [POS_W-1:0] ID_LAST        = 5'd15;
   localparam logic [POS_W-1:0] TAIL_FIRST     = 5'd14;

   localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CH_POINT = 8'h2E;
   localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

   localparam logic [2:0] PLACES_MAX = 3'd7;

   localparam logic [1:0] KIND_NONE    = 2'd0;
   localparam logic [1:0] KIND_WEIGHT  = 2'd1;
   localparam logic [1:0] KIND_DELETED = 2'd2;

   localparam logic [1:0] STATUS_NONE = 2'd0;
   localparam logic [1:0] STATUS_OL   = 2'd1;
   localparam logic [1:0] STATUS_ST   = 2'd2;
   localparam logic [1:0] STATUS_US   = 2'd3;

   localparam logic [1:0] MODE_NONE  = 2'd0;
   localparam logic [1:0] MODE_NET   = 2'd1;
   localparam logic [1:0] MODE_GROSS = 2'd2;

   localparam logic [2:0] UNIT_NONE = 3'd0;
   localparam logic [2:0] UNIT_KG   = 3'd1;
   localparam logic [2:0] UNIT_G    = 3'd2;
   localparam logic [2:0] UNIT_LB   = 3'd3;
   localparam logic [2:0] UNIT_HKG  = 3'd4;
   localparam logic [2:0] UNIT_LBOZ = 3'd5;

   localparam logic [1:0] ID_LEADING = 2'd0;
   localparam logic [1:0] ID_DIGITS  = 2'd1;
   localparam logic [1:0] ID_DONE    = 2'd2;

   typedef struct packed {
      logic [POS_W-1:0]                   position;
      logic                               prev_cr;
      logic [0:HDR_LEN-1][BYTE_W-1:0]     header;
      logic [0:TAIL_LEN-1][BYTE_W-1:0]    tail;
      logic [NUM_W-1:0]                   digit_accum;
      logic [2:0]                         place_count;
      logic                               point_seen;
      logic                               bad;
      logic [NUM_W-1:0]                   snap_digits;
      logic [2:0]                         snap_places;
      logic                               snap_bad;
      logic [NUM_W-1:0]                   id_accum;
      logic [1:0]                         id_phase;
   } line_state_type;

   typedef struct packed {
      logic [1:0]       frame_kind;
      logic [1:0]       status_header;
      logic [1:0]       weigh_mode;
      logic             negative;
      logic [2:0]       unit;
      logic [NUM_W-1:0] value_digits;
      logic [2:0]       decimal_places;
      logic             bad_number;
      logic [NUM_W-1:0] deleted_id;
   } result_type;

   function automatic logic is_digit(input logic [BYTE_W-1:0] b);
      return (b >= CH_ZERO) && (b <= CH_NINE);
   endfunction

   // acc * 10 + digit, kept to NUM_W bits
   function automatic logic [NUM_W-1:0] mul10_add(input logic [NUM_W-1:0] acc,
                                                  input logic [3:0] digit);
      logic [NUM_W-1:0] x8;
      logic [NUM_W-1:0] x2;
      x8 = NUM_W'({acc, 3'b000});
      x2 = NUM_W'({acc, 1'b0});
      return x8 + x2 + NUM_W'(digit);
   endfunction

endpackage

### hdl/swfp_line_track.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// swfp_line_track
// Per-byte line state: position, stored header and tail bytes, and the
// running number, snapshot and item-number accumulators.
// ---------------------------------------------------------------------------
module swfp_line_track (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            step,
   input  logic [swfp_pkg::BYTE_W-1:0]     rx_byte,
   output swfp_pkg::line_state_type        state
);
   import swfp_pkg::*;

   line_state_type state_ff;
   line_state_type state_in;
   logic           digit;
   logic [POS_W-1:0] pos;

   assign pos   = state_ff.position;
   assign digit = is_digit(rx_byte);

   always_comb begin
      state_in = state_ff;
      if (step) begin
         if (rx_byte == CH_LF) begin
            state_in = '0;
         end else begin
            for (int i = 0; i < HDR_LEN; i++) begin
               if (pos == POS_W'(i)) state_in.header[i] = rx_byte;
            end
            for (int i = 0; i < TAIL_LEN; i++) begin
               if (pos == TAIL_FIRST + POS_W'(i)) state_in.tail[i] = rx_byte;
            end

            if (pos >= NUM_FIRST && pos <= NUM_LONG_LAST) begin
               if (digit) begin
                  state_in.digit_accum = mul10_add(state_ff.digit_accum, rx_byte[3:0]);
                  if (state_ff.point_seen && state_ff.place_count < PLACES_MAX)
                     state_in.place_count = state_ff.place_count + 3'd1;
               end else if (rx_byte == CH_POINT) begin
                  if (state_ff.point_seen) state_in.bad = 1'b1;
                  else state_in.point_seen = 1'b1;
               end else if (rx_byte != CH_SPACE) begin
                  state_in.bad = 1'b1;
               end
               // short line ends its number field here
               if (pos == NUM_SHORT_LAST) begin
                  state_in.snap_digits = state_in.digit_accum;
                  state_in.snap_places = state_in.place_count;
                  state_in.snap_bad    = state_in.bad;
               end
            end

            if (pos >= ID_FIRST && pos <= ID_LAST) begin
               if (!(state_ff.id_phase == ID_LEADING && rx_byte == CH_SPACE)) begin
                  if ((state_ff.id_phase == ID_LEADING || state_ff.id_phase == ID_DIGITS)
                      && digit) begin
                     state_in.id_accum = mul10_add(state_ff.id_accum, rx_byte[3:0]);
                     state_in.id_phase = ID_DIGITS;
                  end else begin
                     state_in.id_phase = ID_DONE;
                  end
               end
            end

            state_in.prev_cr = (rx_byte == CH_CR);
            if (pos != POS_MAX) state_in.position = pos + 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= '0;
      else state_ff <= state_in;
   end

   assign state = state_ff;

endmodule

### hdl/swfp_frame_decode.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// swfp_frame_decode
// Builds the result word for the line that a line feed closes.
// ---------------------------------------------------------------------------
module swfp_frame_decode (
   input  swfp_pkg::line_state_type st,
   output swfp_pkg::result_type     res
);
   import swfp_pkg::*;

   logic is_short;
   logic is_long;

   assign is_short = (st.position == SHORT_LF_POS);
   assign is_long  = (st.position == LONG_LF_POS);

   always_comb begin
      res = '0;
      if (st.prev_cr && (is_short || is_long)) begin
         if (is_short && st.header == "DELETED") begin
            res.frame_kind = KIND_DELETED;
            res.deleted_id = st.id_accum;
         end else begin
            res.frame_kind = KIND_WEIGHT;
            if (st.header[0:1] == "OL")      res.status_header = STATUS_OL;
            else if (st.header[0:1] == "ST") res.status_header = STATUS_ST;
            else if (st.header[0:1] == "US") res.status_header = STATUS_US;
            if (st.header[3:4] == "NT")      res.weigh_mode = MODE_NET;
            else if (st.header[3:4] == "GS") res.weigh_mode = MODE_GROSS;
            res.negative = (st.header[6] == CH_MINUS);
            if (is_short) begin
               if (st.tail[0:1] == "lb")      res.unit = UNIT_LB;
               else if (st.tail[0:1] == "kg") res.unit = UNIT_KG;
               else if (st.tail[0:1] == " g") res.unit = UNIT_G;
               res.value_digits   = st.snap_digits;
               res.decimal_places = st.snap_places;
               res.bad_number     = st.snap_bad;
            end else begin
               if (st.tail[1:4] == " hkg")      res.unit = UNIT_HKG;
               else if (st.tail[1:4] == "lboz") res.unit = UNIT_LBOZ;
               res.value_digits   = st.digit_accum;
               res.decimal_places = st.place_count;
               res.bad_number     = st.bad;
            end
         end
      end
   end

endmodule

### hdl/swfp_rsp_reg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// swfp_rsp_reg
// Result register on the response side; reloads in the cycle it drains.
// ---------------------------------------------------------------------------
module swfp_rsp_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  swfp_pkg::result_type res_in,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output swfp_pkg::result_type res_out,
   output logic                 free
);
   import swfp_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   result_type res_ff;

   assign free     = !valid_ff || rsp_ready;
   assign valid_in = load || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (load) res_ff <= res_in;
   end

   assign rsp_valid = valid_ff;
   assign res_out   = res_ff;

endmodule

### hdl/scale_weight_frame_parser.sv
`timescale 1ns / 1ps
`include "scale_weight_frame_parser_macros.svh"
// ---------------------------------------------------------------------------
// scale_weight_frame_parser
// Decodes ASCII weight lines from a weighing indicator, one byte per word.
// ---------------------------------------------------------------------------
// Bytes enter on the req_ channel (req_rx_byte). Every line feed produces one
// word on the rsp_ channel: a weight record, a deleted item record, or an
// unrecognized-line word with all fields zero. Other bytes produce nothing.
// The csr_ channel writes the pause bit; it is always ready. While paused,
// bytes are taken and dropped, a line feed included.
// A line feed accepted into the input register is decoded into the result
// register, which raises rsp_valid. Throughput is one byte per cycle unless
// a line feed waits for the result register; the decode is a single pass
// between the input and result registers.
// When the receiver holds rsp_ready low, the result register keeps its word;
// bytes other than line feed keep flowing, and a line feed waits in the input
// register until the result register drains, which then back-pressures req_.
// Reset (synchronous, active high) clears the line state, the pause bit and
// both valid flags.
// ---------------------------------------------------------------------------
module scale_weight_frame_parser (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [swfp_pkg::BYTE_W-1:0]   req_rx_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [1:0]                    rsp_frame_kind,
   output logic [1:0]                    rsp_status_header,
   output logic [1:0]                    rsp_weigh_mode,
   output logic                          rsp_negative,
   output logic [2:0]                    rsp_unit,
   output logic [swfp_pkg::NUM_W-1:0]    rsp_value_digits,
   output logic [2:0]                    rsp_decimal_places,
   output logic                          rsp_bad_number,
   output logic [swfp_pkg::NUM_W-1:0]    rsp_deleted_id,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic                          csr_paused
);
   import swfp_pkg::*;

   logic              paused_ff;
   logic              in_valid_ff;
   logic              in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              byte_is_lf;
   logic              slot_free;
   logic              advance;
   logic              line_step;
   logic              rsp_load;
   line_state_type    line_st;
   result_type        frame_res;
   result_type        rsp_res;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) paused_ff <= 1'b0;
      else if (csr_valid) paused_ff <= csr_paused;
   end

   // only a line feed needs room in the result register
   assign byte_is_lf = (in_byte_ff == CH_LF);
   assign advance    = in_valid_ff && (!byte_is_lf || paused_ff || slot_free);
   assign line_step  = advance && !paused_ff;
   assign rsp_load   = line_step && byte_is_lf;
   assign req_ready  = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) in_valid_in = 1'b1;
      else if (advance) in_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) in_valid_ff <= 1'b0;
      else in_valid_ff <= in_valid_in;
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) in_byte_ff <= req_rx_byte;
   end

   swfp_line_track u_track (
      .clock   (clock),
      .reset   (reset),
      .step    (line_step),
      .rx_byte (in_byte_ff),
      .state   (line_st)
   );

   swfp_frame_decode u_decode (
      .st  (line_st),
      .res (frame_res)
   );

   swfp_rsp_reg u_rsp (
      .clock     (clock),
      .reset     (reset),
      .load      (rsp_load),
      .res_in    (frame_res),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .res_out   (rsp_res),
      .free      (slot_free)
   );

   assign rsp_frame_kind     = rsp_res.frame_kind;
   assign rsp_status_header  = rsp_res.status_header;
   assign rsp_weigh_mode     = rsp_res.weigh_mode;
   assign rsp_negative       = rsp_res.negative;
   assign rsp_unit           = rsp_res.unit;
   assign rsp_value_digits   = rsp_res.value_digits;
   assign rsp_decimal_places = rsp_res.decimal_places;
   assign rsp_bad_number     = rsp_res.bad_number;
   assign rsp_deleted_id     = rsp_res.deleted_id;

   `SWFP_ASSERT_NOW(a_load_only_on_lf, rsp_load, byte_is_lf && !paused_ff,
      "result loaded from a byte other than line feed")
   `SWFP_ASSERT_NOW(a_plain_byte_never_stalls, in_valid_ff && !byte_is_lf, req_ready,
      "non line feed byte held in input register")
   `SWFP_ASSERT_NEXT(a_position_advances, line_step && !byte_is_lf,
      line_st.position != '0, "line position did not advance")
   `SWFP_ASSERT_NOW(a_non_weight_fields_zero, rsp_valid && rsp_frame_kind != KIND_WEIGHT,
      rsp_status_header == STATUS_NONE && rsp_unit == UNIT_NONE && rsp_value_digits == '0,
      "weight fields set on non-weight word")
   `SWFP_ASSERT_NOW(a_deleted_id_only_deleted, rsp_valid && rsp_frame_kind != KIND_DELETED,
      rsp_deleted_id == '0, "item number set on non-deleted word")

endmodule
